@@ hdl/rdf_pkg.sv @@
// Shared types and constants of the region duplicate filter.
`default_nettype none
package rdf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COORD_W     = 12;
    localparam int RATIO_W     = 8;
    localparam int COUNT_OUT_W = 7;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int AREA_W      = 2 * COORD_W;
    localparam int PROD_W      = AREA_W + RATIO_W;
    localparam int PIPE_LAT    = 3;
    localparam int CFG_IDX_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_NUMERATOR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_DENOMINATOR = CFG_IDX_W'(1);

    localparam logic [RATIO_W-1:0] NUMERATOR_RESET   = RATIO_W'(3);
    localparam logic [RATIO_W-1:0] DENOMINATOR_RESET = RATIO_W'(5);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } t_box;

    typedef struct packed {
        logic [RATIO_W-1:0] num;
        logic [RATIO_W-1:0] den;
    } t_thresh;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage
`default_nettype wire

@@ hdl/rdf_cell.sv @@
// One cell of the box ring: holds one stored box and passes it to its neighbor.
`default_nettype none
module rdf_cell (
    input  wire logic              i_clk,
    input  wire rdf_pkg::t_cell_ctrl i_ctrl,
    input  wire rdf_pkg::t_box     i_new_box,
    input  wire rdf_pkg::t_box     i_next_box,
    output rdf_pkg::t_box          o_box
);
    import rdf_pkg::*;

    t_box r_box;
    t_box n_box;

    always_comb begin
        n_box = r_box;
        if (i_ctrl.load) begin
            n_box = i_new_box;
        end else if (i_ctrl.shift) begin
            n_box = i_next_box;
        end
    end

    always_ff @(posedge i_clk) begin
        r_box <= n_box;
    end

    assign o_box = r_box;

endmodule
`default_nettype wire

@@ hdl/rdf_overlap.sv @@
// Pipelined overlap test of the new box against the stored box at the ring head.
`default_nettype none
module rdf_overlap (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire rdf_pkg::t_box    i_new_box,
    input  wire rdf_pkg::t_box    i_stored_box,
    input  wire rdf_pkg::t_thresh i_thresh,
    output logic                  o_hit
);
    import rdf_pkg::*;

    function automatic logic [COORD_W-1:0] span_overlap(
        input logic [COORD_W-1:0] a0,
        input logic [COORD_W-1:0] al,
        input logic [COORD_W-1:0] b0,
        input logic [COORD_W-1:0] bl
    );
        logic [COORD_W:0] lo;
        logic [COORD_W:0] ae;
        logic [COORD_W:0] be;
        logic [COORD_W:0] hi;
        logic [COORD_W:0] diff;
        lo   = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        ae   = {1'b0, a0} + {1'b0, al};
        be   = {1'b0, b0} + {1'b0, bl};
        hi   = (ae < be) ? ae : be;
        diff = hi - lo;
        // The overlap never exceeds either length, so it fits the coordinate width.
        return (hi > lo) ? diff[COORD_W-1:0] : '0;
    endfunction

    logic                r_v1, r_v2, r_v3;
    logic [COORD_W-1:0]  r_ow, r_oh;
    logic [AREA_W-1:0]   r_area_new, r_area_st;
    logic [AREA_W-1:0]   r_inter, r_amin;
    logic [PROD_W-1:0]   r_lhs, r_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ow       <= span_overlap(i_new_box.x, i_new_box.w, i_stored_box.x, i_stored_box.w);
        r_oh       <= span_overlap(i_new_box.y, i_new_box.h, i_stored_box.y, i_stored_box.h);
        r_area_new <= AREA_W'(i_new_box.w) * AREA_W'(i_new_box.h);
        r_area_st  <= AREA_W'(i_stored_box.w) * AREA_W'(i_stored_box.h);

        r_inter    <= AREA_W'(r_ow) * AREA_W'(r_oh);
        r_amin     <= (r_area_new < r_area_st) ? r_area_new : r_area_st;

        r_lhs      <= PROD_W'(r_inter) * PROD_W'(i_thresh.den);
        r_rhs      <= PROD_W'(r_amin) * PROD_W'(i_thresh.num);
    end

    assign o_hit = r_v3 && (r_lhs > r_rhs);

endmodule
`default_nettype wire

@@ hdl/region_duplicate_filter_core.sv @@
// Top level of the region duplicate filter: cell ring, overlap unit and control.
// Each accepted box is checked against every box kept so far in the frame. The
// stored boxes sit in a ring of TABLE_DEPTH cells that rotates once per box past
// a single three-stage overlap unit. Each box passes through the scan state, in
// which the ring makes one full rotation, the drain state, in which the overlap
// unit empties, and the done state, in which the result goes to the output
// register, whatever the fill level. Input is stalled while a box is in work,
// so no new box is taken before the last one is done; a finished
// result waits in the output register and the next box is taken as soon as the
// block returns to idle. A box that finishes while the previous result is still
// stalled in the output register holds the block, and the input, until that
// result is taken. A box with first set empties the table before it is checked.
// A box that overlaps no stored box is kept and appended; when the table is full
// it is kept with overflow set and is not stored. The overlap threshold is
// written through the configuration port: index 0 is the numerator, index 1 the
// denominator.
`default_nettype none
module region_duplicate_filter_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input words
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_first,
    input  wire logic [rdf_pkg::COORD_W-1:0]   i_box_x,
    input  wire logic [rdf_pkg::COORD_W-1:0]   i_box_y,
    input  wire logic [rdf_pkg::COORD_W-1:0]   i_box_width,
    input  wire logic [rdf_pkg::COORD_W-1:0]   i_box_height,
    // result words
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_kept,
    output logic                               o_overflow,
    output logic [rdf_pkg::COUNT_OUT_W-1:0]    o_stored_count,
    // configuration writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [rdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rdf_pkg::RATIO_W-1:0]   i_cfg_data
);
    import rdf_pkg::*;

    localparam int DRN_W = (PIPE_LAT > 1) ? $clog2(PIPE_LAT) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_step, n_step;
    logic [DRN_W-1:0]   r_drain, n_drain;
    logic               r_dup, n_dup;
    t_box               r_new_box;
    t_thresh            r_thresh;
    logic               r_out_valid, n_out_valid;
    logic               r_kept, r_overflow;
    logic [COUNT_OUT_W-1:0] r_stored_count;

    t_box               w_box [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_load;
    logic               w_hit;
    logic               w_accept;
    logic               w_out_free;
    logic               w_finish;
    logic               w_store;
    logic               w_full;
    logic               w_head_valid;

    assign w_accept     = i_in_valid && (r_state == S_IDLE);
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_finish     = (r_state == S_DONE) && w_out_free;
    assign w_full       = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_store      = w_finish && !r_dup && !w_full;
    assign w_head_valid = (r_state == S_SCAN) && (CNT_W'(r_step) < r_count);

    // Ring of cells: cell 0 is the head; after TABLE_DEPTH shifts the ring is
    // back in storage order, so appends land at the cell given by the count.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_ring
        t_cell_ctrl w_ctrl;
        assign w_load[g]     = w_store && (r_count == CNT_W'(g));
        assign w_ctrl.load   = w_load[g];
        assign w_ctrl.shift  = (r_state == S_SCAN);
        rdf_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_new_box  (r_new_box),
            .i_next_box (w_box[(g + 1) % TABLE_DEPTH]),
            .o_box      (w_box[g])
        );
    end

    rdf_overlap u_overlap (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_head_valid),
        .i_new_box    (r_new_box),
        .i_stored_box (w_box[0]),
        .i_thresh     (r_thresh),
        .o_hit        (w_hit)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_drain     = r_drain;
        n_dup       = r_dup || w_hit;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                    n_step  = '0;
                    n_dup   = 1'b0;
                    if (i_first) begin
                        n_count = '0;
                    end
                end
            end
            S_SCAN: begin
                n_step = r_step + 1'b1;
                if (r_step == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_DRAIN;
                    n_drain = '0;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == DRN_W'(PIPE_LAT - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (w_store) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_drain     <= '0;
            r_dup       <= 1'b0;
            r_out_valid <= 1'b0;
            r_thresh    <= '{num: NUMERATOR_RESET, den: DENOMINATOR_RESET};
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_drain     <= n_drain;
            r_dup       <= n_dup;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_OVERLAP_NUMERATOR:   r_thresh.num <= i_cfg_data;
                    REG_OVERLAP_DENOMINATOR: r_thresh.den <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_new_box <= '{x: i_box_x, y: i_box_y, w: i_box_width, h: i_box_height};
        end
        if (w_finish) begin
            r_kept         <= !r_dup;
            r_overflow     <= !r_dup && w_full;
            r_stored_count <= COUNT_OUT_W'(n_count);
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_kept         = r_kept;
    assign o_overflow     = r_overflow;
    assign o_stored_count = r_stored_count;
    assign o_cfg_ready    = 1'b1;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("stored box count beyond table depth");

    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_load))
        else $error("more than one cell loaded at once");

    a_overflow_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_kept)
        else $error("overflow reported on a dropped box");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish && !r_dup && w_full |=> o_overflow && (r_count == CNT_W'(TABLE_DEPTH)))
        else $error("overflow result without a full table");

    a_no_load_while_rotating: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (w_load == '0))
        else $error("cell loaded while ring rotates");

endmodule
`default_nettype wire
